// ===== design/msp_pkg.sv =====
`default_nettype none

package msp_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int SPEED_W    = 24;
    localparam int DELTA_W    = 31;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // |delta| * 1000 fits in DELTA_W + 10 bits
    localparam int PROD_W = DELTA_W + 10;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd7;

    localparam logic [GAIN_W-1:0]   KP_GAIN_RST       = 16'd256;
    localparam logic [GAIN_W-1:0]   KI_GAIN_RST       = 16'd0;
    localparam logic [GAIN_W-1:0]   KD_GAIN_RST       = 16'd0;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd100;
    localparam logic [LIMIT_W-1:0]  OUT_MIN_RST       = 16'd0;
    localparam logic [LIMIT_W-1:0]  OUT_MAX_RST       = 16'd255;
    localparam logic [SPEED_W-1:0]  TARGET_SPEED_RST  = 24'd0;

endpackage

`default_nettype wire

// ===== design/msp_in_if.sv =====
`default_nettype none

interface msp_in_if import msp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_ms;
    logic [COUNT_W-1:0] encoder_count;
    logic               clear_state;

    modport source (output valid, output now_ms, output encoder_count, output clear_state,
                    input ready);
    modport sink   (input valid, input now_ms, input encoder_count, input clear_state,
                    output ready);
endinterface

`default_nettype wire

// ===== design/msp_out_if.sv =====
`default_nettype none

interface msp_out_if import msp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;
    logic [SPEED_W-1:0]        measured_speed;
    logic [DELTA_W-1:0]        pulse_delta;
    logic                      late_sample;

    modport source (output valid, output drive_value, output measured_speed,
                    output pulse_delta, output late_sample, input ready);
    modport sink   (input valid, input drive_value, input measured_speed,
                    input pulse_delta, input late_sample, output ready);
endinterface

`default_nettype wire

// ===== design/motor_speed_pid_top.sv =====
`default_nettype none
// Inputs are taken only while the sequencer is idle; a new input is not accepted until the last one
// is finished. A too-early input, or one taken while disabled, yields no result.
// The sequencer uses a bit-serial divider (41 steps) and a shift-add multiplier (16 per gain).
// A finished result waits in the output register while the next input is taken.
// Reset (synchronous, active low) restores register defaults and zeroes all controller state.

module motor_speed_pid_top import msp_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    msp_in_if.sink                i_in,
    msp_out_if.source             o_out
);

    localparam int INT_W  = LIMIT_W + GAIN_FRAC_BITS;
    localparam int MPROD_W = GAIN_W + SPEED_W + 1;
    localparam int ACC_W  = ((INT_W > MPROD_W) ? INT_W : MPROD_W) + 3;
    localparam int MUL_CW = $clog2(GAIN_W);
    localparam int DIV_CW = $clog2(PROD_W);
    localparam int STEP_W = (MUL_CW > DIV_CW) ? MUL_CW : DIV_CW;

    localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIFF    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_SCALE   = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_ERR     = 4'd5;
    localparam logic [3:0] S_MUL     = 4'd6;
    localparam logic [3:0] S_CLAMP_I = 4'd7;
    localparam logic [3:0] S_DRIVE   = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    localparam logic [1:0] PH_KI = 2'd0;
    localparam logic [1:0] PH_KP = 2'd1;
    localparam logic [1:0] PH_KD = 2'd2;

    // configuration
    logic [GAIN_W-1:0]          r_kp, n_kp, r_ki, n_ki, r_kd, n_kd;
    logic [PERIOD_W-1:0]        r_period, n_period;
    logic signed [LIMIT_W-1:0]  r_out_min, n_out_min, r_out_max, n_out_max;
    logic [SPEED_W-1:0]         r_target, n_target;
    logic                       r_enable, n_enable;

    // controller state
    logic [TIME_W-1:0]          r_last_time, n_last_time;
    logic [COUNT_W-1:0]         r_prev_count, n_prev_count;
    logic signed [INT_W-1:0]    r_integ, n_integ;
    logic [SPEED_W-1:0]         r_last_speed, n_last_speed;

    // sequencer and datapath
    logic [3:0]                 r_state, n_state;
    logic [1:0]                 r_phase, n_phase;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [TIME_W-1:0]          r_now, n_now, r_dt, n_dt;
    logic [COUNT_W-1:0]         r_cnt, n_cnt, r_cdiff, n_cdiff;
    logic [PERIOD_W-1:0]        r_per, n_per;
    logic [PERIOD_W+1:0]        r_per3, n_per3;
    logic                       r_late, n_late;
    logic [DELTA_W-1:0]         r_delta, n_delta;
    logic [PROD_W-1:0]          r_dvd, n_dvd;
    logic [TIME_W-2:0]          r_rem, n_rem;
    logic [SPEED_W-1:0]         r_quot, n_quot;
    logic                       r_qovf, n_qovf;
    logic [SPEED_W-1:0]         r_speed, n_speed;
    logic signed [SPEED_W:0]    r_err, n_err;
    logic signed [ACC_W-1:0]    r_mcand, n_mcand, r_acc, n_acc;
    logic [GAIN_W-1:0]          r_mplier, n_mplier;
    logic signed [DRIVE_W-1:0]  r_drive, n_drive;

    // output register
    logic                       r_o_valid, n_o_valid;
    logic signed [DRIVE_W-1:0]  r_o_drive, n_o_drive;
    logic [SPEED_W-1:0]         r_o_speed, n_o_speed;
    logic [DELTA_W-1:0]         r_o_delta, n_o_delta;
    logic                       r_o_late, n_o_late;

    // combinational helpers
    logic [PERIOD_W-1:0]        per_eff;
    logic [COUNT_W-1:0]         cdiff_abs;
    logic [PROD_W-1:0]          d_ext;
    logic [TIME_W-1:0]          rem_sh;
    logic                       q_bit;
    logic [TIME_W-1:0]          rem_sub;
    logic [SPEED_W-1:0]         speed_sat;
    logic signed [SPEED_W:0]    err_val;
    logic signed [SPEED_W:0]    dspeed;
    logic signed [ACC_W-1:0]    hi_acc, lo_acc, integ_acc, adj, shifted;
    logic signed [INT_W-1:0]    integ_clamped;
    logic [TIME_W:0]            dt2;

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid          = r_o_valid;
    assign o_out.drive_value    = r_o_drive;
    assign o_out.measured_speed = r_o_speed;
    assign o_out.pulse_delta    = r_o_delta;
    assign o_out.late_sample    = r_o_late;

    assign per_eff   = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign cdiff_abs = r_cdiff[COUNT_W-1] ? (~r_cdiff + COUNT_W'(1)) : r_cdiff;
    assign d_ext     = PROD_W'(r_delta);
    assign dt2       = {r_dt, 1'b0};

    assign rem_sh  = {r_rem, r_dvd[PROD_W-1]};
    assign q_bit   = (rem_sh >= r_dt);
    assign rem_sub = rem_sh - r_dt;

    assign speed_sat = r_qovf ? {SPEED_W{1'b1}} : r_quot;
    assign err_val   = $signed({1'b0, r_target}) - $signed({1'b0, speed_sat});
    assign dspeed    = $signed({1'b0, r_last_speed}) - $signed({1'b0, r_speed});

    assign hi_acc    = {{(ACC_W-LIMIT_W){r_out_max[LIMIT_W-1]}}, r_out_max} <<< GAIN_FRAC_BITS;
    assign lo_acc    = {{(ACC_W-LIMIT_W){r_out_min[LIMIT_W-1]}}, r_out_min} <<< GAIN_FRAC_BITS;
    assign integ_acc = {{(ACC_W-INT_W){r_integ[INT_W-1]}}, r_integ};

    always_comb begin
        if (r_acc > hi_acc) begin
            integ_clamped = hi_acc[INT_W-1:0];
        end else if (r_acc < lo_acc) begin
            integ_clamped = lo_acc[INT_W-1:0];
        end else begin
            integ_clamped = r_acc[INT_W-1:0];
        end
    end

    // truncation toward zero
    assign adj     = r_acc + (r_acc[ACC_W-1] ? $signed(FRAC_MASK) : $signed(ACC_W'(0)));
    assign shifted = adj >>> GAIN_FRAC_BITS;

    always_comb begin
        n_kp = r_kp; n_ki = r_ki; n_kd = r_kd; n_period = r_period;
        n_out_min = r_out_min; n_out_max = r_out_max; n_target = r_target;
        n_enable = r_enable;
        n_last_time = r_last_time; n_prev_count = r_prev_count;
        n_integ = r_integ; n_last_speed = r_last_speed;
        n_state = r_state; n_phase = r_phase; n_step = r_step;
        n_now = r_now; n_cnt = r_cnt; n_dt = r_dt; n_cdiff = r_cdiff;
        n_per = r_per; n_per3 = r_per3; n_late = r_late; n_delta = r_delta;
        n_dvd = r_dvd; n_rem = r_rem; n_quot = r_quot; n_qovf = r_qovf;
        n_speed = r_speed; n_err = r_err; n_mcand = r_mcand; n_acc = r_acc;
        n_mplier = r_mplier; n_drive = r_drive;
        n_o_valid = r_o_valid; n_o_drive = r_o_drive; n_o_speed = r_o_speed;
        n_o_delta = r_o_delta; n_o_late = r_o_late;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KP_GAIN:       n_kp = i_cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:       n_ki = i_cfg_data[GAIN_W-1:0];
                REG_KD_GAIN:       n_kd = i_cfg_data[GAIN_W-1:0];
                REG_SAMPLE_PERIOD: n_period = i_cfg_data[PERIOD_W-1:0];
                REG_OUT_MIN:       n_out_min = i_cfg_data[LIMIT_W-1:0];
                REG_OUT_MAX:       n_out_max = i_cfg_data[LIMIT_W-1:0];
                REG_TARGET_SPEED:  n_target = i_cfg_data[SPEED_W-1:0];
                REG_ENABLE:        n_enable = i_cfg_data[0];
                default:           n_enable = r_enable;
            endcase
        end

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_now = i_in.now_ms;
                    n_cnt = i_in.encoder_count;
                    if (i_in.clear_state) begin
                        n_integ      = '0;
                        n_last_speed = '0;
                    end
                    if (r_enable) begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_dt    = r_now - r_last_time;
                n_cdiff = r_cnt - r_prev_count;
                n_per   = per_eff;
                n_per3  = (PERIOD_W+2)'(per_eff) + {1'b0, per_eff, 1'b0};
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_dt[TIME_W-1] || (r_dt < TIME_W'(r_per))) begin
                    n_state = S_IDLE;
                end else begin
                    n_late       = (dt2 > (TIME_W+1)'(r_per3));
                    n_delta      = cdiff_abs[COUNT_W-1] ? {DELTA_W{1'b1}}
                                                        : cdiff_abs[DELTA_W-1:0];
                    n_last_time  = r_now;
                    n_prev_count = r_cnt;
                    n_state      = S_SCALE;
                end
            end
            S_SCALE: begin
                // x1000 = x1024 - x32 + x8
                n_dvd   = (d_ext << 10) - (d_ext << 5) + (d_ext << 3);
                n_rem   = '0;
                n_quot  = '0;
                n_qovf  = 1'b0;
                n_step  = STEP_W'(PROD_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = q_bit ? rem_sub[TIME_W-2:0] : rem_sh[TIME_W-2:0];
                n_dvd  = r_dvd << 1;
                n_quot = {r_quot[SPEED_W-2:0], q_bit};
                n_qovf = r_qovf | r_quot[SPEED_W-1];
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_speed = speed_sat;
                n_err   = err_val;
                if (!err_val[SPEED_W] && (err_val != '0)) begin
                    n_acc    = integ_acc;
                    n_mcand  = {{(ACC_W-SPEED_W-1){err_val[SPEED_W]}}, err_val};
                    n_mplier = r_ki;
                    n_phase  = PH_KI;
                    n_step   = STEP_W'(GAIN_W - 1);
                    n_state  = S_MUL;
                end else begin
                    n_drive = '0;
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand <<< 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    case (r_phase)
                        PH_KI: begin
                            n_state = S_CLAMP_I;
                        end
                        PH_KP: begin
                            // derivative on measurement, subtracted via (last - speed)
                            n_mcand  = {{(ACC_W-SPEED_W-1){dspeed[SPEED_W]}}, dspeed};
                            n_mplier = r_kd;
                            n_phase  = PH_KD;
                            n_step   = STEP_W'(GAIN_W - 1);
                        end
                        default: begin
                            n_state = S_DRIVE;
                        end
                    endcase
                end
            end
            S_CLAMP_I: begin
                n_integ  = integ_clamped;
                n_acc    = {{(ACC_W-INT_W){integ_clamped[INT_W-1]}}, integ_clamped};
                n_mcand  = {{(ACC_W-SPEED_W-1){r_err[SPEED_W]}}, r_err};
                n_mplier = r_kp;
                n_phase  = PH_KP;
                n_step   = STEP_W'(GAIN_W - 1);
                n_state  = S_MUL;
            end
            S_DRIVE: begin
                if (r_acc > hi_acc) begin
                    n_drive = r_out_max;
                end else if (r_acc < lo_acc) begin
                    n_drive = r_out_min;
                end else begin
                    n_drive = shifted[DRIVE_W-1:0];
                end
                n_last_speed = r_speed;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_drive = r_drive;
                    n_o_speed = r_speed;
                    n_o_delta = r_delta;
                    n_o_late  = r_late;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= KP_GAIN_RST;
            r_ki         <= KI_GAIN_RST;
            r_kd         <= KD_GAIN_RST;
            r_period     <= SAMPLE_PERIOD_RST;
            r_out_min    <= OUT_MIN_RST;
            r_out_max    <= OUT_MAX_RST;
            r_target     <= TARGET_SPEED_RST;
            r_enable     <= 1'b0;
            r_last_time  <= '0;
            r_prev_count <= '0;
            r_integ      <= '0;
            r_last_speed <= '0;
            r_state      <= S_IDLE;
            r_o_valid    <= 1'b0;
        end else begin
            r_kp         <= n_kp;
            r_ki         <= n_ki;
            r_kd         <= n_kd;
            r_period     <= n_period;
            r_out_min    <= n_out_min;
            r_out_max    <= n_out_max;
            r_target     <= n_target;
            r_enable     <= n_enable;
            r_last_time  <= n_last_time;
            r_prev_count <= n_prev_count;
            r_integ      <= n_integ;
            r_last_speed <= n_last_speed;
            r_state      <= n_state;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_step    <= n_step;
        r_now     <= n_now;
        r_cnt     <= n_cnt;
        r_dt      <= n_dt;
        r_cdiff   <= n_cdiff;
        r_per     <= n_per;
        r_per3    <= n_per3;
        r_late    <= n_late;
        r_delta   <= n_delta;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_qovf    <= n_qovf;
        r_speed   <= n_speed;
        r_err     <= n_err;
        r_mcand   <= n_mcand;
        r_acc     <= n_acc;
        r_mplier  <= n_mplier;
        r_drive   <= n_drive;
        r_o_drive <= n_o_drive;
        r_o_speed <= n_o_speed;
        r_o_delta <= n_o_delta;
        r_o_late  <= n_o_late;
    end

endmodule

`default_nettype wire
